// ----- src/transport_sweep_recurrence_macros.svh -----
// ----------------------------------------------------------------------------
// Transport sweep assertion macros
// Shared property forms for the concurrent assertions of the sweep block.
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_SWEEP_RECURRENCE_MACROS_SVH
`define TRANSPORT_SWEEP_RECURRENCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transport sweep assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transport sweep assertion failed");

`endif

// ----- src/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Transport sweep package
// Item types, operation codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package tsr_pkg;

   localparam int DIRECTIONS_DEF = 16;
   localparam int REGIONS_DEF    = 16;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [1:0] {
      OP_LOAD_COEF    = 2'd0,
      OP_LOAD_SOURCE  = 2'd1,
      OP_SET_BOUNDARY = 2'd2,
      OP_SWEEP        = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL1,
      ST_DIFF,
      ST_MUL2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic               backward;
      logic [3:0]         region;
      logic [3:0]         direction;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
      logic               last_cell;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_direction;
      logic signed [31:0] flux;
      logic               last;
      logic               sweep_end;
   } rsp_type;

   // Step controls from the sequencer to the tables and the arithmetic unit.
   typedef struct packed {
      logic       rd_en;
      logic       src_rd_en;
      logic       mul_en;
      logic       mul_second;
      logic       diff_en;
      logic       emit;
      logic       last;
      logic       sweep_end;
      logic [3:0] out_dir;
   } ctrl_type;

endpackage

// ----- src/tsr_tables.sv -----
// ----------------------------------------------------------------------------
// Transport sweep tables
// Coefficient, region source and edge flux memories with registered reads.
// ----------------------------------------------------------------------------
`include "transport_sweep_recurrence_macros.svh"

module tsr_tables #(
   parameter int DIRECTIONS = tsr_pkg::DIRECTIONS_DEF,
   parameter int REGIONS    = tsr_pkg::REGIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_accept,
   input  tsr_pkg::req_type                    req_item,
   input  tsr_pkg::ctrl_type                   ctrl,
   input  logic [3:0]                          rd_region,
   input  logic [$clog2(DIRECTIONS)-1:0]       rd_dir,
   input  logic [$clog2(DIRECTIONS)-1:0]       wr_dir,
   input  logic signed [31:0]                  wr_value,
   output logic signed [31:0]                  feed_value,
   output logic signed [31:0]                  scale_value,
   output logic signed [31:0]                  source_value,
   output logic signed [31:0]                  edge_value
);
   import tsr_pkg::*;

   localparam int DIR_AW     = $clog2(DIRECTIONS);
   localparam int DIR_W      = (DIR_AW > 4) ? DIR_AW : 4;
   localparam int COEF_DEPTH = REGIONS * DIRECTIONS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int RGN_AW     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int RGN_W      = (RGN_AW > 4) ? RGN_AW : 4;

   logic signed [31:0] feed_mem   [COEF_DEPTH];
   logic signed [31:0] scale_mem  [COEF_DEPTH];
   logic signed [31:0] source_mem [REGIONS];
   logic signed [31:0] edge_mem   [DIRECTIONS];

   logic [DIRECTIONS-1:0] edge_valid_ff;
   logic signed [31:0]    feed_rd_ff;
   logic signed [31:0]    scale_rd_ff;
   logic signed [31:0]    source_rd_ff;
   logic signed [31:0]    edge_rd_ff;
   logic                  edge_ok_ff;

   logic               region_ok;
   logic               dir_ok;
   logic               coef_we;
   logic               source_we;
   logic               boundary_we;
   logic               edge_we;
   logic [DIR_W-1:0]   dir_wide;
   logic [DIR_AW-1:0]  dir_idx;
   logic [RGN_W-1:0]   wr_region_wide;
   logic [RGN_W-1:0]   rd_region_wide;
   logic [RGN_AW-1:0]  wr_region_idx;
   logic [RGN_AW-1:0]  rd_region_idx;
   logic [COEF_AW-1:0] coef_wr_addr;
   logic [COEF_AW-1:0] coef_rd_addr;
   logic [DIR_AW-1:0]  edge_wr_addr;
   logic signed [31:0] edge_wr_data;

   assign region_ok = 32'(req_item.region) < REGIONS;
   assign dir_ok    = 32'(req_item.direction) < DIRECTIONS;

   assign coef_we     = req_accept && (req_item.operation == OP_LOAD_COEF)
                        && region_ok && dir_ok;
   assign source_we   = req_accept && (req_item.operation == OP_LOAD_SOURCE) && region_ok;
   assign boundary_we = req_accept && (req_item.operation == OP_SET_BOUNDARY) && dir_ok;

   assign dir_wide       = DIR_W'(req_item.direction);
   assign dir_idx        = dir_wide[DIR_AW-1:0];
   assign wr_region_wide = RGN_W'(req_item.region);
   assign wr_region_idx  = wr_region_wide[RGN_AW-1:0];
   assign rd_region_wide = RGN_W'(rd_region);
   assign rd_region_idx  = rd_region_wide[RGN_AW-1:0];

   // Row per region, one entry per direction within the row.
   assign coef_wr_addr = COEF_AW'(32'(req_item.region) * DIRECTIONS
                                  + 32'(req_item.direction));
   assign coef_rd_addr = COEF_AW'(32'(rd_region) * DIRECTIONS + 32'(rd_dir));

   // Boundary loads only arrive while the sequencer is idle, so they never
   // meet a swept result on the edge write port.
   assign edge_we      = boundary_we || ctrl.emit;
   assign edge_wr_addr = boundary_we ? dir_idx : wr_dir;
   assign edge_wr_data = boundary_we ? req_item.first_value : wr_value;

   always_ff @(posedge clock) begin
      if (coef_we) begin
         feed_mem[coef_wr_addr]  <= req_item.first_value;
         scale_mem[coef_wr_addr] <= req_item.second_value;
      end
      if (ctrl.rd_en) begin
         feed_rd_ff  <= feed_mem[coef_rd_addr];
         scale_rd_ff <= scale_mem[coef_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (source_we) begin
         source_mem[wr_region_idx] <= req_item.first_value;
      end
      if (ctrl.src_rd_en) begin
         source_rd_ff <= source_mem[rd_region_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wr_addr] <= edge_wr_data;
      end
      if (ctrl.rd_en) begin
         edge_rd_ff <= edge_mem[rd_dir];
         edge_ok_ff <= edge_valid_ff[rd_dir];
      end
   end

   // An edge entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_valid_ff <= '0;
      end else if (edge_we) begin
         edge_valid_ff[edge_wr_addr] <= 1'b1;
      end
   end

   assign feed_value   = feed_rd_ff;
   assign scale_value  = scale_rd_ff;
   assign source_value = source_rd_ff;
   assign edge_value   = edge_ok_ff ? edge_rd_ff : '0;

   `TSR_ASSERT_IMPLIES(a_edge_port_exclusive, clock, reset, boundary_we, !ctrl.emit)

endmodule

// ----- src/tsr_datapath.sv -----
// ----------------------------------------------------------------------------
// Transport sweep arithmetic unit
// Shared signed multiplier with rounding, saturation and the result register.
// ----------------------------------------------------------------------------
`include "transport_sweep_recurrence_macros.svh"

module tsr_datapath #(
   parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  tsr_pkg::ctrl_type  ctrl,
   input  logic signed [31:0] cell_value,
   input  logic signed [31:0] source_value,
   input  logic signed [31:0] feed_value,
   input  logic signed [31:0] scale_value,
   input  logic signed [31:0] edge_value,
   output logic signed [31:0] result,
   output logic               rsp_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tsr_pkg::rsp_type   rsp_item
);
   import tsr_pkg::*;

   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   logic signed [31:0] op_a;
   logic signed [31:0] op_b;
   logic signed [63:0] prod_in;
   logic signed [63:0] prod_ff;
   logic signed [63:0] rounded;
   logic signed [65:0] diff_wide;
   logic signed [31:0] diff_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // The first pass forms feed times edge, the second the clamped difference
   // times scale.
   assign op_a    = ctrl.mul_second ? diff_ff : feed_value;
   assign op_b    = ctrl.mul_second ? scale_value : edge_value;
   assign prod_in = op_a * op_b;

   // Round half up: add one half, then shift arithmetically (floor).
   assign rounded   = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
   assign diff_wide = 66'(cell_value) + 66'(source_value) - 66'(rounded);
   assign result    = sat32(66'(rounded));

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.diff_en) begin
         diff_ff <= sat32(diff_wide);
      end
      if (ctrl.emit) begin
         rsp_ff.out_direction <= ctrl.out_dir;
         rsp_ff.flux          <= result;
         rsp_ff.last          <= ctrl.last;
         rsp_ff.sweep_end     <= ctrl.sweep_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `TSR_ASSERT_NEXT(a_emit_shows_item, clock, reset, ctrl.emit, rsp_valid_ff)

endmodule

// ----- src/tsr_seq.sv -----
// ----------------------------------------------------------------------------
// Transport sweep sequencer
// Steps one cell through its directions, two multiplications per direction.
// ----------------------------------------------------------------------------
`include "transport_sweep_recurrence_macros.svh"

module tsr_seq #(
   parameter int DIRECTIONS = tsr_pkg::DIRECTIONS_DEF,
   parameter int REGIONS    = tsr_pkg::REGIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tsr_pkg::req_type              req_item,
   input  logic                          rsp_free,
   output tsr_pkg::ctrl_type             ctrl,
   output logic [3:0]                    rd_region,
   output logic [$clog2(DIRECTIONS)-1:0] rd_dir,
   output logic [$clog2(DIRECTIONS)-1:0] wr_dir,
   output logic signed [31:0]            cell_value
);
   import tsr_pkg::*;

   localparam int DIR_AW    = $clog2(DIRECTIONS);
   localparam int DIR_W     = (DIR_AW > 4) ? DIR_AW : 4;
   localparam int HALF_DIRS = DIRECTIONS / 2;

   localparam logic [DIR_AW-1:0] FWD_FIRST = '0;
   localparam logic [DIR_AW-1:0] FWD_LAST  = DIR_AW'(HALF_DIRS - 1);
   localparam logic [DIR_AW-1:0] BWD_FIRST = DIR_AW'(HALF_DIRS);
   localparam logic [DIR_AW-1:0] BWD_LAST  = DIR_AW'(DIRECTIONS - 1);

   state_type         state_ff;
   state_type         state_in;
   logic [DIR_AW-1:0] m_ff;
   logic [DIR_AW-1:0] m_in;
   req_type           item_ff;
   logic              start;
   logic              is_last;
   logic [DIR_W-1:0]  m_wide;

   // A sweep of a region outside the tables is dropped like a load.
   assign start   = req_valid && req_ready && (req_item.operation == OP_SWEEP)
                    && (32'(req_item.region) < REGIONS);
   assign is_last = m_ff == (item_ff.backward ? BWD_LAST : FWD_LAST);
   assign m_wide  = DIR_W'(m_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:  state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = is_last ? ST_IDLE : ST_MUL1;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      m_in = m_ff;
      if (start) begin
         m_in = req_item.backward ? BWD_FIRST : FWD_FIRST;
      end else if ((state_ff == ST_FINISH) && rsp_free && !is_last) begin
         m_in = DIR_AW'(m_ff + 1'b1);
      end
   end

   always_comb begin
      req_ready      = 1'b0;
      ctrl           = '0;
      ctrl.last      = is_last;
      ctrl.sweep_end = is_last && item_ff.last_cell;
      ctrl.out_dir   = m_wide[3:0];
      rd_dir         = m_ff;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FETCH: begin
            ctrl.rd_en     = 1'b1;
            ctrl.src_rd_en = 1'b1;
         end
         ST_MUL1:   ctrl.mul_en = 1'b1;
         ST_DIFF:   ctrl.diff_en = 1'b1;
         ST_MUL2: begin
            // Fetch the next direction's operands while this one finishes.
            ctrl.mul_en     = 1'b1;
            ctrl.mul_second = 1'b1;
            ctrl.rd_en      = !is_last;
            rd_dir          = DIR_AW'(m_ff + 1'b1);
         end
         ST_FINISH: ctrl.emit = rsp_free;
         default:   req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      if (start) begin
         item_ff <= req_item;
      end
   end

   assign rd_region  = item_ff.region;
   assign wr_dir     = m_ff;
   assign cell_value = item_ff.first_value;

   `TSR_ASSERT_NEXT(a_start_fetches, clock, reset, start, state_ff == ST_FETCH)
   `TSR_ASSERT_NEXT(a_stall_holds_dir, clock, reset, (state_ff == ST_FINISH) && !rsp_free, $stable(m_ff))

endmodule

// ----- src/transport_sweep_recurrence.sv -----
// ----------------------------------------------------------------------------
// Transport sweep recurrence
// Slab discrete-ordinates cell sweep in signed fixed point on one multiplier.
// ----------------------------------------------------------------------------
// Channel  Ports                             Carries
// req      req_valid req_ready req_item      table loads, boundary sets, cells
// rsp      rsp_valid rsp_ready rsp_item      one new edge flux per direction
//
// Loads and boundary sets are written on acceptance. A cell sweeps
// DIRECTIONS/2 (lower half) or the remaining directions (upper half) and,
// after a fetch step, takes two multiplications per direction on the shared
// multiplier; no new request is accepted until it is done. A stalled result
// holds the block in its finishing step. Reset clears only the sequencer,
// the result valid and the edge valid bits; no clearing pass is run.
// ----------------------------------------------------------------------------
module transport_sweep_recurrence #(
   parameter int DIRECTIONS = tsr_pkg::DIRECTIONS_DEF,
   parameter int REGIONS    = tsr_pkg::REGIONS_DEF,
   parameter int FRAC_BITS  = tsr_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tsr_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tsr_pkg::rsp_type rsp_item
);
   import tsr_pkg::*;

   localparam int DIR_AW = $clog2(DIRECTIONS);

   ctrl_type           ctrl;
   logic               rsp_free;
   logic [3:0]         rd_region;
   logic [DIR_AW-1:0]  rd_dir;
   logic [DIR_AW-1:0]  wr_dir;
   logic signed [31:0] cell_value;
   logic signed [31:0] feed_value;
   logic signed [31:0] scale_value;
   logic signed [31:0] source_value;
   logic signed [31:0] edge_value;
   logic signed [31:0] result;

   tsr_seq #(
      .DIRECTIONS (DIRECTIONS),
      .REGIONS    (REGIONS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_free   (rsp_free),
      .ctrl       (ctrl),
      .rd_region  (rd_region),
      .rd_dir     (rd_dir),
      .wr_dir     (wr_dir),
      .cell_value (cell_value)
   );

   tsr_tables #(
      .DIRECTIONS (DIRECTIONS),
      .REGIONS    (REGIONS)
   ) u_tables (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_valid && req_ready),
      .req_item     (req_item),
      .ctrl         (ctrl),
      .rd_region    (rd_region),
      .rd_dir       (rd_dir),
      .wr_dir       (wr_dir),
      .wr_value     (result),
      .feed_value   (feed_value),
      .scale_value  (scale_value),
      .source_value (source_value),
      .edge_value   (edge_value)
   );

   tsr_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cell_value   (cell_value),
      .source_value (source_value),
      .feed_value   (feed_value),
      .scale_value  (scale_value),
      .edge_value   (edge_value),
      .result       (result),
      .rsp_free     (rsp_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item)
   );

endmodule
